>>> sv/rrtp_pkg.sv
`timescale 1ns / 1ps
// Types and codes shared by the round robin task picker.
package rrtp_pkg;

    localparam int KIND_W  = 2;
    localparam int TICK_W  = 32;
    localparam int CFG_W   = 4;
    localparam int CHOSE_W = 3;
    localparam int MODE_W  = 2;
    localparam int ENTRY_W = MODE_W + TICK_W;

    localparam logic [KIND_W-1:0] KIND_SCHED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SLEEP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START = 2'd2;

    localparam logic [MODE_W-1:0] MODE_NEW   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SLEEP = 2'd2;

    localparam logic [CFG_W-1:0] TASK_COUNT_RST = 4'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_START,
        ST_DELIVER
    } t_state;

    typedef struct packed {
        logic               none_runnable;
        logic               fresh_start;
        logic               switched;
        logic [CHOSE_W-1:0] chosen_task;
    } t_result;

endpackage

>>> sv/round_robin_task_picker_core.sv
`timescale 1ns / 1ps
// Round robin task picker: task table in a synchronous memory, scan sequencer.
//
//  channel  | dir | handshake                      | payload
//  ---------+-----+--------------------------------+-------------------------------------
//  s (item) | in  | i_s_tvalid / o_s_tready        | tuser kind, tdata now, sleep_length
//  m (res)  | out | o_m_tvalid / i_m_tready        | tdata chosen, switched, fresh, none
//  cfg      | in  | i_cfg_wr_en                    | i_cfg_wr_data task_count
//
// Schedule item: one memory read per visited slot, pipelined one slot a cycle; the scan
// visits at most task count slots (0 read as 1, capped at MAX_TASKS) before delivering.
// Sleep and unused kinds go straight to deliver; start passes through the start state first.
// Reset marks every slot as new through per-slot valid bits; no clearing pass.
// A stalled result is held in the output register while the next item is taken;
// the item after that waits until the held result is transferred.
module round_robin_task_picker_core
    import rrtp_pkg::*;
#(
    parameter int MAX_TASKS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [KIND_W-1:0]     i_s_tuser,     // [1:0] kind
    input  logic [2*TICK_W-1:0]   i_s_tdata,     // [31:0] now, [63:32] sleep_length
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,     // [2:0] chosen_task, [3] switched,
                                                 // [4] fresh_start, [5] none_runnable
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_W-1:0]      i_cfg_wr_data
);

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = SLOT_W + 1;

    t_state                r_state, n_state;
    logic [SLOT_W-1:0]     r_run, n_run;
    logic [CNT_W-1:0]      r_left, n_left;
    logic [SLOT_W-1:0]     r_idx, n_idx;
    logic [SLOT_W-1:0]     r_rd_idx, n_rd_idx;
    logic                  r_rd_vld, n_rd_vld;
    logic                  r_rd_last, n_rd_last;
    logic [TICK_W-1:0]     r_now, n_now;
    t_result               r_pend, n_pend;
    t_result               r_out, n_out;
    logic                  r_out_vld, n_out_vld;
    logic [CFG_W-1:0]      r_task_count;
    logic [MAX_TASKS-1:0]  r_vld;

    logic [ENTRY_W-1:0]    r_mem [MAX_TASKS];
    logic [ENTRY_W-1:0]    r_rd_data;

    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata;
    logic [SLOT_W-1:0]     mem_raddr;

    logic [CNT_W-1:0]      cnt_eff;
    logic [MODE_W-1:0]     rd_mode;
    logic [TICK_W-1:0]     rd_wake;
    logic                  wake;
    logic                  can_run;
    logic [TICK_W-1:0]     in_now;
    logic [TICK_W-1:0]     in_len;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                     input logic [CNT_W-1:0]  cnt);
        logic [CNT_W-1:0] inc;
        inc = {1'b0, s} + CNT_W'(1);
        return (inc >= cnt) ? '0 : inc[SLOT_W-1:0];
    endfunction

    assign in_now = i_s_tdata[TICK_W-1:0];
    assign in_len = i_s_tdata[2*TICK_W-1:TICK_W];

    always_comb begin
        if (r_task_count == '0) begin
            cnt_eff = CNT_W'(1);
        end else if (32'(r_task_count) > MAX_TASKS) begin
            cnt_eff = CNT_W'(MAX_TASKS);
        end else begin
            cnt_eff = CNT_W'(r_task_count);
        end
    end

    assign rd_mode = r_vld[r_rd_idx] ? r_rd_data[ENTRY_W-1:TICK_W] : MODE_NEW;
    assign rd_wake = r_rd_data[TICK_W-1:0];
    assign wake    = (rd_mode == MODE_SLEEP) && (rd_wake <= r_now);
    assign can_run = (rd_mode == MODE_NEW) || (rd_mode == MODE_RUN) || wake;

    always_comb begin
        n_state   = r_state;
        n_run     = r_run;
        n_left    = r_left;
        n_idx     = r_idx;
        n_rd_idx  = r_rd_idx;
        n_rd_vld  = 1'b0;
        n_rd_last = 1'b0;
        n_now     = r_now;
        n_pend    = r_pend;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_m_tready;
        mem_we    = 1'b0;
        mem_waddr = r_run;
        mem_wdata = {MODE_RUN, {TICK_W{1'b0}}};
        mem_raddr = r_idx;
        o_s_tready = (r_state == ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    unique case (i_s_tuser)
                        KIND_SCHED: begin
                            n_left  = cnt_eff;
                            n_idx   = next_slot(r_run, cnt_eff);
                            n_now   = in_now;
                            n_state = ST_SCAN;
                        end
                        KIND_SLEEP: begin
                            mem_we    = 1'b1;
                            mem_waddr = r_run;
                            mem_wdata = {MODE_SLEEP, in_now + in_len};
                            n_pend    = '{1'b0, 1'b0, 1'b0, CHOSE_W'(r_run)};
                            n_state   = ST_DELIVER;
                        end
                        KIND_START: begin
                            mem_raddr = '0;
                            n_rd_idx  = '0;
                            n_rd_vld  = 1'b1;
                            n_state   = ST_START;
                        end
                        default: begin
                            n_pend  = '{1'b0, 1'b0, 1'b0, CHOSE_W'(r_run)};
                            n_state = ST_DELIVER;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_left != '0) begin
                    n_rd_vld  = 1'b1;
                    n_rd_idx  = r_idx;
                    n_rd_last = (r_left == CNT_W'(1));
                    n_idx     = next_slot(r_idx, cnt_eff);
                    n_left    = r_left - CNT_W'(1);
                end
                if (r_rd_vld) begin
                    if (can_run) begin
                        n_rd_vld  = 1'b0;
                        n_run     = r_rd_idx;
                        mem_waddr = r_rd_idx;
                        mem_wdata = {MODE_RUN, {TICK_W{1'b0}}};
                        mem_we    = wake || ((rd_mode == MODE_NEW) && (r_rd_idx != r_run));
                        n_pend    = '{1'b0,
                                      (rd_mode == MODE_NEW) && (r_rd_idx != r_run),
                                      r_rd_idx != r_run,
                                      CHOSE_W'(r_rd_idx)};
                        n_state   = ST_DELIVER;
                    end else if (r_rd_last) begin
                        n_pend  = '{1'b1, 1'b0, 1'b0, CHOSE_W'(r_run)};
                        n_state = ST_DELIVER;
                    end
                end
            end
            ST_START: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = {MODE_RUN, {TICK_W{1'b0}}};
                n_run     = '0;
                n_pend    = '{1'b0, rd_mode == MODE_NEW, r_run != '0, CHOSE_W'(0)};
                n_state   = ST_DELIVER;
            end
            ST_DELIVER: begin
                if (!r_out_vld || i_m_tready) begin
                    n_out     = r_pend;
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_run        <= '0;
            r_left       <= '0;
            r_rd_vld     <= 1'b0;
            r_rd_last    <= 1'b0;
            r_out_vld    <= 1'b0;
            r_task_count <= TASK_COUNT_RST;
            r_vld        <= '0;
        end else begin
            r_state   <= n_state;
            r_run     <= n_run;
            r_left    <= n_left;
            r_rd_vld  <= n_rd_vld;
            r_rd_last <= n_rd_last;
            r_out_vld <= n_out_vld;
            if (i_cfg_wr_en) begin
                r_task_count <= i_cfg_wr_data;
            end
            if (mem_we) begin
                r_vld[mem_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_rd_idx <= n_rd_idx;
        r_now    <= n_now;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {2'b00, r_out.none_runnable, r_out.fresh_start, r_out.switched,
                         r_out.chosen_task};

    a_rd_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == ST_SCAN || r_state == ST_START))
        else $error("memory read pending outside scan or start");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result not held");

    a_none_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[5]) |-> (!o_m_tdata[3] && !o_m_tdata[4]))
        else $error("empty scan reported a switch");

    a_no_write_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state != ST_DELIVER))
        else $error("task table written while delivering");

endmodule

>>> tb/sv/tb_round_robin_task_picker_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the round robin task picker core.
module tb_round_robin_task_picker_core;
    import rrtp_pkg::*;

    localparam int                SLOT_MAX   = 8;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int                SETTLE_CYC = 16;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                i_s_tvalid    = 1'b0;
    logic                o_s_tready;
    logic [KIND_W-1:0]   i_s_tuser     = KIND_SCHED;  // [1:0] kind
    logic [2*TICK_W-1:0] i_s_tdata     = '0;          // [31:0] now, [63:32] sleep_length
    logic                o_m_tvalid;
    logic                i_m_tready    = 1'b0;
    logic [7:0]          o_m_tdata;                   // [2:0] chosen_task, [3] switched,
                                                      // [4] fresh_start, [5] none_runnable
    logic                i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wr_data = '0;

    // Task table as the block should hold it.
    logic [MODE_W-1:0] slot_mode  [SLOT_MAX];
    logic [TICK_W-1:0] slot_begin [SLOT_MAX];
    logic [TICK_W-1:0] slot_span  [SLOT_MAX];
    logic [CHOSE_W-1:0] cur_slot;
    logic [CFG_W-1:0]   task_count;

    t_result     picks_due[$];
    int unsigned errors;
    int unsigned gap_pct;
    int unsigned stall_pct;
    logic [TICK_W-1:0] tick_now;

    round_robin_task_picker_core #(
        .MAX_TASKS(SLOT_MAX)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tuser    (i_s_tuser),
        .i_s_tdata    (i_s_tdata),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_result pick_next(logic [KIND_W-1:0] kind, logic [TICK_W-1:0] now,
                                          logic [TICK_W-1:0] len);
        t_result           r;
        logic [CHOSE_W-1:0] prev;
        logic [TICK_W-1:0] wake_at;
        int unsigned       cnt;
        int unsigned       idx;
        bit                found;
        prev = cur_slot;
        r = '0;
        r.chosen_task = prev;
        case (kind)
            KIND_SCHED: begin
                cnt = (task_count == 0) ? 1 : (task_count > SLOT_MAX) ? SLOT_MAX : task_count;
                idx = prev;
                found = 1'b0;
                r.none_runnable = 1'b1;
                for (int n = 0; n < cnt && !found; n++) begin
                    idx = (idx + 1 >= cnt) ? 0 : idx + 1;
                    wake_at = slot_begin[idx] + slot_span[idx];
                    if (slot_mode[idx] == MODE_SLEEP && wake_at <= now) begin
                        slot_mode[idx]  = MODE_RUN;
                        slot_begin[idx] = '0;
                        slot_span[idx]  = '0;
                    end
                    if (slot_mode[idx] == MODE_NEW || slot_mode[idx] == MODE_RUN) begin
                        found = 1'b1;
                        cur_slot = CHOSE_W'(idx);
                        r.chosen_task = CHOSE_W'(idx);
                        r.none_runnable = 1'b0;
                        r.switched = (idx != prev);
                        if (idx != prev && slot_mode[idx] == MODE_NEW) begin
                            slot_mode[idx] = MODE_RUN;
                            r.fresh_start = 1'b1;
                        end
                    end
                end
            end
            KIND_SLEEP: begin
                slot_mode[prev]  = MODE_SLEEP;
                slot_begin[prev] = now;
                slot_span[prev]  = len;
            end
            KIND_START: begin
                r.fresh_start = (slot_mode[0] == MODE_NEW);
                r.switched = (prev != 0);
                r.chosen_task = '0;
                slot_mode[0] = MODE_RUN;
                cur_slot = '0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic send_item(logic [KIND_W-1:0] kind, logic [TICK_W-1:0] now,
                             logic [TICK_W-1:0] len);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {len, now};
        do @(posedge i_clk); while (!o_s_tready);
        picks_due.push_back(pick_next(kind, now, len));
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (picks_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_count(logic [CFG_W-1:0] value);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        task_count = value;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic report_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_result'(o_m_tdata[5:0]);
            if (picks_due.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual %h", $time, o_m_tdata);
                errors++;
            end else begin
                want = picks_due.pop_front();
                report_field("chosen_task", want.chosen_task, got.chosen_task);
                report_field("switched", want.switched, got.switched);
                report_field("fresh_start", want.fresh_start, got.fresh_start);
                report_field("none_runnable", want.none_runnable, got.none_runnable);
            end
        end
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Slot 0 alone and still new: the scan comes back to it without a fresh start.
    task automatic test_single_new_slot();
        write_count(4'd0);
        send_item(KIND_SCHED, 32'd0, 32'd0);
        send_item(KIND_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Start, sleep, wake with and without tick wrap, nothing runnable.
    task automatic test_sleep_and_wake();
        write_count(TASK_COUNT_RST);
        send_item(KIND_SCHED, 32'd0, 32'd0);
        send_item(KIND_START, 32'd5, 32'd0);
        send_item(KIND_SLEEP, 32'd100, 32'd50);
        send_item(KIND_SCHED, 32'd120, 32'd0);
        send_item(KIND_SLEEP, 32'hFFFF_FFF0, 32'h20);
        send_item(KIND_SCHED, 32'd0, 32'd0);
        send_item(KIND_SCHED, 32'h10, 32'd0);
        send_item(KIND_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(KIND_SLEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(KIND_SCHED, 32'hFFFF_FFFF, 32'h0);
    endtask

    // Shrink the count below the running slot so the scan restarts at slot 0.
    task automatic test_slot_beyond_count();
        write_count(4'd15);
        repeat (3) send_item(KIND_SCHED, 32'd200, 32'd0);
        send_item(KIND_SLEEP, 32'd201, 32'd3);
        write_count(TASK_COUNT_RST);
        send_item(KIND_SCHED, 32'd202, 32'd0);
        send_item(KIND_SCHED, 32'd203, 32'd0);
    endtask

    task automatic test_random_traffic(logic [CFG_W-1:0] count, int unsigned n_items);
        int unsigned       roll;
        logic [KIND_W-1:0] kind;
        logic [TICK_W-1:0] now;
        logic [TICK_W-1:0] len;
        write_count(count);
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 52)      kind = KIND_SCHED;
            else if (roll < 80) kind = KIND_SLEEP;
            else if (roll < 96) kind = KIND_START;
            else                kind = KIND_SPARE;
            if ($urandom_range(0, 99) < 3) tick_now = $urandom;
            else tick_now = tick_now + $urandom_range(0, 6);
            now = ($urandom_range(0, 99) < 4) ? $urandom : tick_now;
            roll = $urandom_range(0, 99);
            if (roll < 70)      len = $urandom_range(0, 24);
            else if (roll < 85) len = $urandom;
            else                len = 32'hFFFF_FFFF - $urandom_range(0, 24);
            send_item(kind, now, len);
        end
    endtask

    initial begin
        for (int s = 0; s < SLOT_MAX; s++) begin
            slot_mode[s]  = MODE_NEW;
            slot_begin[s] = '0;
            slot_span[s]  = '0;
        end
        cur_slot     = '0;
        task_count   = TASK_COUNT_RST;
        errors       = 0;
        tick_now     = '0;
        gap_pct      = 8;
        stall_pct    = 56;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_new_slot();
        test_sleep_and_wake();
        test_slot_beyond_count();

        test_random_traffic(4'd8, 160);
        test_random_traffic(4'd1, 160);
        test_random_traffic(4'd3, 160);
        test_random_traffic(4'd15, 160);

        gap_pct   = 56;
        stall_pct = 8;
        test_random_traffic(4'd0, 160);
        test_random_traffic(4'd5, 160);
        test_random_traffic(4'd2, 160);
        test_random_traffic(4'd12, 160);

        gap_pct   = 0;
        stall_pct = 0;
        test_random_traffic(4'd7, 160);
        test_random_traffic(4'd4, 160);
        test_random_traffic(4'd6, 160);
        test_random_traffic(4'd8, 160);

        settle();
        if (errors == 0 && picks_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
sv/rrtp_pkg.sv
sv/round_robin_task_picker_core.sv
tb/sv/tb_round_robin_task_picker_core.sv
